>>> hdl/kmp_pkg.sv
// -----------------------------------------------------------------------------
// kmp_pkg: shared types and constants for the pattern occurrence counter
// Command and status codes, field widths and the per-cell control word.
// -----------------------------------------------------------------------------
`default_nettype none

package kmp_pkg;

  // Field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STS_W   = 2;
  localparam int unsigned COUNT_W = 32;

  // Default pattern store depth
  localparam int unsigned DEFAULT_PATTERN_DEPTH = 256;

  // Command codes
  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_CLEAR  = 2'd0;
  localparam cmd_t CMD_APPEND = 2'd1;
  localparam cmd_t CMD_TEXT   = 2'd2;

  // Status codes
  typedef logic [STS_W-1:0] status_t;
  localparam status_t STS_OK   = 2'd0;
  localparam status_t STS_FULL = 2'd1;
  localparam status_t STS_SAT  = 2'd2;

  // Control word broadcast to every cell
  typedef struct packed {
    logic              load;   // write chr into the first free cell past the pattern tail
    logic              step;   // shift one text character through the prefix bits
    logic              clear;  // drop all live prefix bits
    logic [CHAR_W-1:0] chr;
  } cell_ctrl_t;

endpackage : kmp_pkg

`default_nettype wire

>>> hdl/kmp_cell.sv
// -----------------------------------------------------------------------------
// kmp_cell: one pattern position of the matcher chain
// Holds one pattern character and one prefix bit: the bit is set when the
// pattern prefix that ends at this position is a suffix of the text so far.
// On each text character the bit is taken from the left neighbor and qualified
// by a character compare.
// -----------------------------------------------------------------------------
`default_nettype none

module kmp_cell import kmp_pkg::*; #(
  parameter int unsigned PATTERN_DEPTH = DEFAULT_PATTERN_DEPTH,
  parameter int unsigned CELL_IDX      = 0,
  localparam int unsigned LEN_W        = $clog2(PATTERN_DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [LEN_W-1:0] len_i,
  input  wire logic             prev_hit_i,
  output logic                  hit_o,
  output logic                  tail_hit_o
);

  logic [CHAR_W-1:0] pat_q;
  logic              hit_q, hit_d;
  logic              live;
  logic              tail;

  // Position is part of the pattern, and whether it is the last one
  assign live = len_i > LEN_W'(CELL_IDX);
  assign tail = len_i == LEN_W'(CELL_IDX + 1);

  // Capture the pattern character when the append lands here
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && (len_i == LEN_W'(CELL_IDX))) begin
      pat_q <= ctrl_i.chr;
    end
  end

  // Advance the prefix bit from the neighbor
  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.clear) begin
      hit_d = 1'b0;
    end else if (ctrl_i.step) begin
      hit_d = prev_hit_i & live & (pat_q == ctrl_i.chr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign hit_o      = hit_q;
  assign tail_hit_o = hit_q & tail;

endmodule : kmp_cell

`default_nettype wire

>>> hdl/kmp_pattern_occurrence_counter.sv
// -----------------------------------------------------------------------------
// Flow: the cell chain updates when an input word is taken; the tail reduction
// and counter update follow in ST_FIN, where the result word is loaded once
// the output register is free; input stalls whenever the FSM is not in ST_IDLE.
// Reset: pattern length, prefix bits, count and handshake state clear at once.
// -----------------------------------------------------------------------------
// kmp_pattern_occurrence_counter: streaming pattern occurrence counter
// A chain of cells, one per pattern position, tracks every pattern prefix that
// ends the text seen so far; an occurrence ends where the tail cell is set.
// -----------------------------------------------------------------------------
`default_nettype none

module kmp_pattern_occurrence_counter import kmp_pkg::*; #(
  parameter int unsigned PATTERN_DEPTH = DEFAULT_PATTERN_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input words
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [CMD_W-1:0]   cmd_i,
  input  wire logic [CHAR_W-1:0]  char_code_i,
  input  wire logic               end_of_text_i,
  // result words
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    match_here_o,
  output logic [COUNT_W-1:0]      match_count_o,
  output logic [STS_W-1:0]        status_o,
  output logic                    last_out_o
);

  localparam int unsigned LEN_W = $clog2(PATTERN_DEPTH + 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FIN  = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [LEN_W-1:0]   len_q;
  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W-1:0] count_n;
  cmd_t               cmd_q;
  logic               last_q;
  logic               full_q;
  logic               is_full;
  logic               accept_in;
  logic               out_free;
  logic               fin_fire;
  logic               is_text;
  logic               hit;

  cell_ctrl_t         ctrl;
  logic [PATTERN_DEPTH-1:0] hit_vec;
  logic [PATTERN_DEPTH-1:0] prev_vec;
  logic [PATTERN_DEPTH-1:0] tail_vec;

  logic               out_valid_q;
  logic               match_here_q;
  logic [COUNT_W-1:0] match_count_q;
  status_t            status_q;
  logic               last_out_q;

  // Handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept_in  = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign fin_fire   = (state_q == ST_FIN) & out_free;
  assign is_full    = (len_q == LEN_W'(PATTERN_DEPTH));
  assign is_text    = (cmd_q == CMD_TEXT);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_in) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Drive the cell chain
  always_comb begin
    ctrl.load  = accept_in && (cmd_i == CMD_APPEND) && !is_full;
    ctrl.step  = accept_in && (cmd_i == CMD_TEXT);
    ctrl.clear = (accept_in && (cmd_i == CMD_CLEAR)) || (fin_fire && is_text && last_q);
    ctrl.chr   = char_code_i;
  end

  for (genvar g = 0; g < PATTERN_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_vec[g] = 1'b1;
    end else begin : g_body
      assign prev_vec[g] = hit_vec[g-1];
    end

    kmp_cell #(
      .PATTERN_DEPTH(PATTERN_DEPTH),
      .CELL_IDX     (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .len_i     (len_q),
      .prev_hit_i(prev_vec[g]),
      .hit_o     (hit_vec[g]),
      .tail_hit_o(tail_vec[g])
    );
  end

  // Occurrence ends here: tail cell set, or every character with no pattern
  assign hit     = (len_q == '0) | (|tail_vec);
  assign count_n = (hit && (count_q != COUNT_MAX)) ? count_q + COUNT_W'(1) : count_q;

  // Hold the accepted command for the result cycle
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      cmd_q  <= cmd_i;
      last_q <= end_of_text_i;
      full_q <= (cmd_i == CMD_APPEND) && is_full;
    end
  end

  // Control state: state, pattern length, count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept_in && (cmd_i == CMD_CLEAR)) begin
        len_q   <= '0;
        count_q <= '0;
      end else if (ctrl.load) begin
        len_q <= len_q + LEN_W'(1);
      end
      if (fin_fire && is_text) begin
        count_q <= last_q ? '0 : count_n;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      match_here_q  <= is_text & hit;
      match_count_q <= is_text ? count_n : count_q;
      last_out_q    <= is_text & last_q;
      if (is_text && (count_n == COUNT_MAX)) begin
        status_q <= STS_SAT;
      end else if ((cmd_q == CMD_APPEND) && full_q) begin
        status_q <= STS_FULL;
      end else begin
        status_q <= STS_OK;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_here_o  = match_here_q;
  assign match_count_o = match_count_q;
  assign status_o      = status_q;
  assign last_out_o    = last_out_q;

  // Checks
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(PATTERN_DEPTH))
    else $error("pattern length beyond store depth");

  a_load_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result word loaded outside the result cycle");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_in && (cmd_i == CMD_CLEAR)) |=> (len_q == '0) && (hit_vec == '0))
    else $error("clear left pattern or prefix bits behind");

  a_empty_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_fire && is_text && (len_q == '0)) |=> match_here_o)
    else $error("text word with empty pattern did not match");

endmodule : kmp_pattern_occurrence_counter

`default_nettype wire

>>> dv/tb.sv
// -----------------------------------------------------------------------------
// tb: testbench for kmp_pattern_occurrence_counter
// Drives clear, pattern, text and unused command words with random gaps and
// stalls the result side at random. A scoreboard predicts each result word with
// a Knuth-Morris-Pratt model of its own and checks every field in order.
// -----------------------------------------------------------------------------
`default_nettype none

module tb;
  import kmp_pkg::*;

  localparam int unsigned DEPTH        = DEFAULT_PATTERN_DEPTH;
  localparam int unsigned RANDOM_WORDS = 1500;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam cmd_t        CMD_UNUSED   = 2'd3;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] count;
    status_t            sts;
    logic               last;
  } occurrence_t;

  // Predict result words and compare them with what the block returns
  class occurrence_scoreboard;
    logic [CHAR_W-1:0] pat_bytes [DEPTH];
    int unsigned       links [DEPTH+1];
    int unsigned       pat_len;
    int unsigned       match_pos;
    logic [COUNT_W-1:0] occ_count;
    occurrence_t       pending [$];
    int unsigned       mismatches;
    int unsigned       words_checked;
    int unsigned       hits_seen;
    int unsigned       dropped;

    function new();
      pat_len       = 0;
      match_pos     = 0;
      occ_count     = '0;
      mismatches    = 0;
      words_checked = 0;
      hits_seen     = 0;
      dropped       = 0;
    endfunction

    // Walk the failure links until the next byte extends the prefix
    function int unsigned fall_back(int unsigned p, logic [CHAR_W-1:0] c);
      while (p != 0 && pat_bytes[p] != c) p = links[p];
      return p;
    endfunction

    function void note_word(cmd_t cmd, logic [CHAR_W-1:0] c, logic eot);
      occurrence_t exp;
      int unsigned j;
      exp = '0;
      case (cmd)
        CMD_CLEAR: begin
          pat_len   = 0;
          match_pos = 0;
          occ_count = '0;
        end
        CMD_APPEND: begin
          if (pat_len >= DEPTH) begin
            exp.sts = STS_FULL;
            dropped++;
          end else begin
            pat_bytes[pat_len] = c;
            if (pat_len == 0) begin
              links[0] = 0;
              links[1] = 0;
            end else begin
              j = fall_back(links[pat_len], c);
              links[pat_len+1] = (pat_bytes[j] == c) ? j + 1 : 0;
            end
            pat_len++;
          end
        end
        CMD_TEXT: begin
          // an empty pattern matches at every byte
          if (pat_len == 0) begin
            exp.hit = 1'b1;
          end else begin
            j = match_pos;
            if (j >= pat_len) j = links[pat_len];
            j = fall_back(j, c);
            if (pat_bytes[j] == c) j++;
            match_pos = j;
            exp.hit   = (j == pat_len);
          end
          if (exp.hit && occ_count != '1) occ_count++;
          if (occ_count == '1) exp.sts = STS_SAT;
          exp.last = eot;
        end
        default: ;
      endcase
      exp.count = occ_count;
      if (cmd == CMD_TEXT && eot) begin
        match_pos = 0;
        occ_count = '0;
      end
      pending.push_back(exp);
    endfunction

    function void check_word(logic hit, logic [COUNT_W-1:0] count, status_t sts,
                             logic last);
      occurrence_t exp;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
        return;
      end
      exp = pending.pop_front();
      words_checked++;
      if (hit) hits_seen++;
      if (hit !== exp.hit) begin
        $error("match_here: expected %0d, got %0d", exp.hit, hit);
        mismatches++;
      end
      if (count !== exp.count) begin
        $error("match_count: expected %0d, got %0d", exp.count, count);
        mismatches++;
      end
      if (sts !== exp.sts) begin
        $error("status: expected %0d, got %0d", exp.sts, sts);
        mismatches++;
      end
      if (last !== exp.last) begin
        $error("last_out: expected %0d, got %0d", exp.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  cmd_t               cmd;
  logic [CHAR_W-1:0]  char_code;
  logic               end_of_text;
  logic               out_valid;
  logic               out_stall;
  logic               match_here;
  logic [COUNT_W-1:0] match_count;
  logic [STS_W-1:0]   status;
  logic               last_out;

  occurrence_scoreboard sb = new();

  bit          idling   = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned sent_words = 0;
  int unsigned cycles     = 0;

  kmp_pattern_occurrence_counter #(
    .PATTERN_DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .char_code_i  (char_code),
    .end_of_text_i(end_of_text),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .match_here_o (match_here),
    .match_count_o(match_count),
    .status_o     (status),
    .last_out_o   (last_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_word(match_here, match_count, status, last_out);
    end
  end

  // Stall the result side in random bursts, and once for a long stretch
  initial begin
    int unsigned burst_left;
    int unsigned hold_left;
    burst_left = 0;
    hold_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (idling && $urandom_range(0, 9) == 0) begin
        out_stall  <= 1'b1;
        burst_left = $urandom_range(1, 12) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one word, with an optional gap first, and hold it until taken
  task automatic send_word(cmd_t c, logic [CHAR_W-1:0] chr, logic eot);
    int unsigned gap;
    @(negedge clk);
    if (idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    char_code   <= chr;
    end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(c, chr, eot);
    if (c != CMD_UNUSED) sent_words++;
  endtask

  // One session: maybe clear, load a pattern from a small alphabet, stream texts
  task automatic run_session();
    logic [CHAR_W-1:0] alpha [4];
    logic [CHAR_W-1:0] chr;
    int unsigned       n_sym;
    int unsigned       plen;
    int unsigned       tlen;
    int unsigned       roll;
    bit                close_text;
    n_sym = $urandom_range(1, 4);
    foreach (alpha[k]) alpha[k] = CHAR_W'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) alpha[0] = 8'h00;
    if ($urandom_range(0, 9) == 0) alpha[n_sym-1] = 8'hFF;
    // skip the clear now and then so the old pattern grows
    if ($urandom_range(0, 9) != 0) begin
      send_word(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    roll = $urandom_range(0, 99);
    if (roll < 5)       plen = 0;
    else if (roll < 88) plen = $urandom_range(1, 6);
    else if (roll < 97) plen = $urandom_range(7, 40);
    else                plen = $urandom_range(200, DEPTH + 4);
    repeat (plen) begin
      send_word(CMD_APPEND, alpha[$urandom_range(0, n_sym - 1)],
                1'($urandom_range(0, 1)));
    end
    repeat ($urandom_range(1, 3)) begin
      tlen = (plen > 40) ? $urandom_range(plen, plen + 40) : $urandom_range(1, 48);
      close_text = ($urandom_range(0, 9) != 0);
      for (int t = 0; t < tlen; t++) begin
        roll = $urandom_range(0, 99);
        chr  = (roll < 6) ? CHAR_W'($urandom_range(0, 255))
                          : alpha[$urandom_range(0, n_sym - 1)];
        if (roll < 2) begin
          send_word(CMD_UNUSED, chr, 1'($urandom_range(0, 1)));
        end else if (roll < 4) begin
          send_word(CMD_APPEND, alpha[$urandom_range(0, n_sym - 1)], 1'b0);
        end else begin
          send_word(CMD_TEXT, chr, close_text && (t == tlen - 1));
        end
      end
    end
  endtask

  initial begin
    int unsigned random_base;
    bit          hold_done;
    hold_done   = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    cmd         = CMD_CLEAR;
    char_code   = '0;
    end_of_text = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Empty pattern: every text byte matches
    send_word(CMD_TEXT, 8'h00, 1'b0);
    send_word(CMD_TEXT, 8'hFF, 1'b1);
    send_word(CMD_TEXT, 8'h5A, 1'b0);
    // Unused command changes nothing
    send_word(CMD_UNUSED, 8'hFF, 1'b1);
    // Overlapping occurrences of "aba"
    send_word(CMD_APPEND, 8'h61, 1'b1);
    send_word(CMD_APPEND, 8'h62, 1'b0);
    send_word(CMD_APPEND, 8'h61, 1'b0);
    send_word(CMD_TEXT, 8'h61, 1'b0);
    send_word(CMD_TEXT, 8'h62, 1'b0);
    send_word(CMD_TEXT, 8'h61, 1'b0);
    send_word(CMD_TEXT, 8'h62, 1'b0);
    send_word(CMD_TEXT, 8'h61, 1'b0);
    // Grow the pattern while the text runs
    send_word(CMD_APPEND, 8'h62, 1'b0);
    send_word(CMD_TEXT, 8'h62, 1'b0);
    send_word(CMD_TEXT, 8'h61, 1'b0);
    send_word(CMD_TEXT, 8'h62, 1'b1);
    // Zero byte is an ordinary character
    send_word(CMD_CLEAR, 8'hFF, 1'b1);
    send_word(CMD_APPEND, 8'h00, 1'b0);
    send_word(CMD_APPEND, 8'h00, 1'b0);
    send_word(CMD_TEXT, 8'h00, 1'b0);
    send_word(CMD_TEXT, 8'h00, 1'b0);
    send_word(CMD_TEXT, 8'h00, 1'b0);
    send_word(CMD_TEXT, 8'hFF, 1'b1);
    // Fill the store, then overflow it by one byte
    send_word(CMD_CLEAR, 8'h00, 1'b0);
    for (int k = 0; k < DEPTH; k++) send_word(CMD_APPEND, (k % 2) ? 8'hFF : 8'h00, 1'b0);
    send_word(CMD_APPEND, 8'h55, 1'b0);
    send_word(CMD_TEXT, 8'h00, 1'b0);
    send_word(CMD_TEXT, 8'hFF, 1'b1);
    send_word(CMD_CLEAR, 8'h00, 1'b0);

    // Random sessions; hold the result side once, drop idling near the end
    random_base = sent_words;
    while (sent_words - random_base < RANDOM_WORDS) begin
      if (!hold_done && sent_words - random_base > 600) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (sent_words - random_base > RANDOM_WORDS - 250) idling = 1'b0;
      run_session();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain outstanding results
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input words, %0d result words checked, %0d occurrences",
             sent_words, sb.words_checked, sb.hits_seen);
    $display("  %0d pattern bytes dropped on a full store, %0d mismatches",
             sb.dropped, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hdl/kmp_pkg.sv
hdl/kmp_cell.sv
hdl/kmp_pattern_occurrence_counter.sv
dv/tb.sv
